/* hw/rtl/sct_pkg.sv */
package sct_pkg;

    localparam int ROW_W   = 10;
    localparam int COL_W   = 10;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 13;
    localparam int CNT_W   = 13;
    localparam int REQ_W   = 3;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD     = 3'd0,
        REQ_BUILD    = 3'd1,
        REQ_RD_ENTRY = 3'd2,
        REQ_RD_OFF   = 3'd3,
        REQ_START    = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_BUILT = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_COLUMNS = 1'b0,
        CFG_NUM_ROWS    = 1'b1
    } cfg_idx_t;

    // loaded nonzero as kept in the load store
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } ld_word_t;

    // transposed entry
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [ROW_W-1:0] index;
        logic [COL_W-1:0] row;
    } out_word_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [ROW_W-1:0] out_index;
        logic [COL_W-1:0] out_row;
        logic [VAL_W-1:0] out_value;
        status_t          status;
    } res_t;

    typedef struct packed {
        logic ld_we;
        logic out_we;
    } entry_ctl_t;

    typedef struct packed {
        logic cnt_we;
        logic cur_we;
        logic off_we;
    } col_ctl_t;

endpackage

/* hw/rtl/sct_entry_mem.sv */
module sct_entry_mem import sct_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic        aclk,
    input  entry_ctl_t  ctl,
    input  logic [AW-1:0] ld_waddr,
    input  ld_word_t    ld_wdata,
    input  logic [AW-1:0] ld_raddr,
    output ld_word_t    ld_rdata,
    input  logic [AW-1:0] out_waddr,
    input  out_word_t   out_wdata,
    input  logic [AW-1:0] out_raddr,
    output out_word_t   out_rdata
);

    ld_word_t  ld_mem  [DEPTH];
    out_word_t out_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.ld_we) begin
            ld_mem[ld_waddr] <= ld_wdata;
        end
        ld_rdata <= ld_mem[ld_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_we) begin
            out_mem[out_waddr] <= out_wdata;
        end
        out_rdata <= out_mem[out_raddr];
    end

endmodule

/* hw/rtl/sct_col_mem.sv */
module sct_col_mem import sct_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int W     = 13
) (
    input  logic          aclk,
    input  col_ctl_t      ctl,
    input  logic [AW-1:0] cnt_waddr,
    input  logic [W-1:0]  cnt_wdata,
    input  logic [AW-1:0] cnt_raddr,
    output logic [W-1:0]  cnt_rdata,
    input  logic [AW-1:0] cur_waddr,
    input  logic [W-1:0]  cur_wdata,
    input  logic [AW-1:0] cur_raddr,
    output logic [W-1:0]  cur_rdata,
    input  logic [AW-1:0] off_waddr,
    input  logic [W-1:0]  off_wdata,
    input  logic [AW-1:0] off_raddr,
    output logic [W-1:0]  off_rdata
);

    // per-column entry counts, fill cursors, and offsets shifted by one
    // (off_mem[c] holds the end offset of column c; offset 0 is implied)
    logic [W-1:0] cnt_mem [DEPTH];
    logic [W-1:0] cur_mem [DEPTH];
    logic [W-1:0] off_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ctl.cur_we) begin
            cur_mem[cur_waddr] <= cur_wdata;
        end
        cur_rdata <= cur_mem[cur_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ctl.off_we) begin
            off_mem[off_waddr] <= off_wdata;
        end
        off_rdata <= off_mem[off_raddr];
    end

endmodule

/* hw/rtl/sparse_csr_transpose_top.sv */
// channel   dir  tdata (low bit up)                         tuser     tlast
// s_        in   row, column, value, position (zero fill)   req_type  -
// m_        out  status, out_value, out_row, out_index, count  -      -
//
// Load, read entry, read offset: one registered memory access, then the response state.
// Rejected items, offset zero and unknown types go straight to the response state. Build: a
// read and a write step per column for the prefix sum, then read, cursor and write steps per
// loaded entry for the scatter, on one adder. Reset and config writes clear all MAX_COLUMNS
// column counts; start does the same, then responds. No item is taken meanwhile.
// A finished result waits in the output register; the next item is taken while it waits.
module sparse_csr_transpose_top import sct_pkg::*; #(
    parameter int MAX_NONZEROS = 4096,
    parameter int MAX_COLUMNS  = 1024,
    parameter int MAX_ROWS     = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [71:0]          s_tdata,   // row, column, value, position
    input  logic [REQ_W-1:0]     s_tuser,   // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,   // status, out_value, out_row, out_index, count
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int NZW = $clog2(MAX_NONZEROS + 1);
    localparam int EAW = $clog2(MAX_NONZEROS);
    localparam int CAW = $clog2(MAX_COLUMNS);
    localparam int NCW = $clog2(MAX_COLUMNS + 1);
    localparam int NCOL_RST = (MAX_COLUMNS < 1024) ? MAX_COLUMNS : 1024;
    localparam int NROW_RST = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_CLR    = 11'b000_0000_0010,
        S_LD_RMW = 11'b000_0000_0100,
        S_PF_RD  = 11'b000_0000_1000,
        S_PF_WR  = 11'b000_0001_0000,
        S_SC_RD  = 11'b000_0010_0000,
        S_SC_CUR = 11'b000_0100_0000,
        S_SC_WR  = 11'b000_1000_0000,
        S_RD_ENT = 11'b001_0000_0000,
        S_RD_OFF = 11'b010_0000_0000,
        S_RESP   = 11'b100_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [NZW-1:0]     total_reg, total_next;
    logic               built_reg, built_next;
    logic [CFG_W-1:0]   ncol_reg, ncol_next;
    logic [CFG_W-1:0]   nrow_reg, nrow_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [NCW-1:0]     c_reg, c_next;
    logic [NZW-1:0]     i_reg, i_next;
    logic [NZW-1:0]     acc_reg, acc_next;
    logic [CAW-1:0]     clr_reg, clr_next;
    logic               pend_reg, pend_next;
    res_t               res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    res_t               m_data_reg, m_data_next;

    logic [ROW_W-1:0]   in_row;
    logic [COL_W-1:0]   in_col;
    logic [VAL_W-1:0]   in_val;
    logic [POS_W-1:0]   in_pos;
    logic               accept;
    logic               out_free;

    entry_ctl_t         e_ctl;
    col_ctl_t           c_ctl;
    ld_word_t           ld_wdata;
    ld_word_t           ld_rdata;
    out_word_t          out_wdata;
    out_word_t          out_rdata;
    logic [NZW-1:0]     cnt_rdata, cur_rdata, off_rdata;
    logic [CAW-1:0]     cnt_waddr, cnt_raddr, cur_waddr;
    logic [NZW-1:0]     cnt_wdata, cur_wdata;

    // shared adder
    logic [NZW-1:0]     add_a, add_b, sum;

    logic [CFG_W-1:0]   cfg_clamped_col, cfg_clamped_row;

    assign in_row = s_tdata[9:0];
    assign in_col = s_tdata[19:10];
    assign in_val = s_tdata[51:20];
    assign in_pos = s_tdata[64:52];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_data_reg};

    always_comb begin
        unique case (state_reg)
            S_LD_RMW: begin add_a = cnt_rdata; add_b = NZW'(1); end
            S_PF_WR:  begin add_a = acc_reg;   add_b = cnt_rdata; end
            default:  begin add_a = cur_rdata; add_b = NZW'(1); end
        endcase
    end
    assign sum = add_a + add_b;

    always_comb begin
        cfg_clamped_col = cfg_data;
        if (cfg_data == '0) begin
            cfg_clamped_col = CFG_W'(1);
        end else if (32'(cfg_data) > MAX_COLUMNS) begin
            cfg_clamped_col = CFG_W'(MAX_COLUMNS);
        end
        cfg_clamped_row = cfg_data;
        if (cfg_data == '0) begin
            cfg_clamped_row = CFG_W'(1);
        end else if (32'(cfg_data) > MAX_ROWS) begin
            cfg_clamped_row = CFG_W'(MAX_ROWS);
        end
    end

    // memory addressing
    assign cnt_raddr = (state_reg == S_PF_RD) ? CAW'(c_reg) : CAW'(in_col);
    assign cnt_waddr = (state_reg == S_CLR) ? clr_reg : CAW'(col_reg);
    assign cnt_wdata = (state_reg == S_CLR) ? '0 : sum;
    assign cur_waddr = (state_reg == S_PF_WR) ? CAW'(c_reg) : CAW'(ld_rdata.column);
    assign cur_wdata = (state_reg == S_PF_WR) ? acc_reg : sum;

    assign ld_wdata  = {in_val, in_col, in_row};
    assign out_wdata = {ld_rdata.value, ld_rdata.row, ld_rdata.column};

    always_comb begin
        e_ctl.ld_we  = 1'b0;
        e_ctl.out_we = (state_reg == S_SC_WR);
        c_ctl.cnt_we = (state_reg == S_CLR) || (state_reg == S_LD_RMW);
        c_ctl.cur_we = (state_reg == S_PF_WR) || (state_reg == S_SC_WR);
        c_ctl.off_we = (state_reg == S_PF_WR);

        state_next   = state_reg;
        total_next   = total_reg;
        built_next   = built_reg;
        ncol_next    = ncol_reg;
        nrow_next    = nrow_reg;
        col_next     = col_reg;
        c_next       = c_reg;
        i_next       = i_reg;
        acc_next     = acc_reg;
        clr_next     = clr_reg;
        pend_next    = pend_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_next   = '0;
                    state_next = S_RESP;
                    unique case (s_tuser)
                        REQ_LOAD: begin
                            if (in_row >= nrow_reg || in_col >= ncol_reg) begin
                                res_next.status = ST_RANGE;
                            end else if (total_reg == NZW'(MAX_NONZEROS)) begin
                                res_next.status = ST_FULL;
                            end else begin
                                e_ctl.ld_we = 1'b1;
                                col_next    = in_col;
                                state_next  = S_LD_RMW;
                            end
                        end
                        REQ_BUILD: begin
                            c_next     = '0;
                            acc_next   = '0;
                            state_next = S_PF_RD;
                        end
                        REQ_RD_ENTRY: begin
                            if (!built_reg) begin
                                res_next.status = ST_NOT_BUILT;
                            end else if (32'(in_pos) >= 32'(total_reg)) begin
                                res_next.status = ST_RANGE;
                            end else begin
                                state_next = S_RD_ENT;
                            end
                        end
                        REQ_RD_OFF: begin
                            if (!built_reg) begin
                                res_next.status = ST_NOT_BUILT;
                            end else if (in_pos > POS_W'(ncol_reg)) begin
                                res_next.status = ST_RANGE;
                            end else if (in_pos != '0) begin
                                state_next = S_RD_OFF;
                            end
                        end
                        REQ_START: begin
                            total_next = '0;
                            built_next = 1'b0;
                            clr_next   = '0;
                            pend_next  = 1'b1;
                            state_next = S_CLR;
                        end
                        default: begin
                            res_next.count = CNT_W'(total_reg);
                        end
                    endcase
                end
            end
            S_CLR: begin
                clr_next = clr_reg + CAW'(1);
                if (clr_reg == CAW'(MAX_COLUMNS - 1)) begin
                    state_next = pend_reg ? S_RESP : S_IDLE;
                    pend_next  = 1'b0;
                end
            end
            S_LD_RMW: begin
                total_next     = total_reg + NZW'(1);
                built_next     = 1'b0;
                res_next.count = CNT_W'(total_reg + NZW'(1));
                state_next     = S_RESP;
            end
            S_PF_RD: begin
                state_next = S_PF_WR;
            end
            S_PF_WR: begin
                acc_next = sum;
                c_next   = c_reg + NCW'(1);
                if (32'(c_reg) + 1 == 32'(ncol_reg)) begin
                    i_next     = '0;
                    state_next = (total_reg == '0) ? S_RESP : S_SC_RD;
                    built_next = (total_reg == '0);
                    res_next.count = CNT_W'(total_reg);
                end else begin
                    state_next = S_PF_RD;
                end
            end
            S_SC_RD: begin
                state_next = S_SC_CUR;
            end
            S_SC_CUR: begin
                state_next = S_SC_WR;
            end
            S_SC_WR: begin
                i_next = i_reg + NZW'(1);
                if (i_reg + NZW'(1) == total_reg) begin
                    built_next = 1'b1;
                    state_next = S_RESP;
                end else begin
                    state_next = S_SC_RD;
                end
            end
            S_RD_ENT: begin
                res_next.out_value = out_rdata.value;
                res_next.out_row   = out_rdata.row;
                res_next.out_index = out_rdata.index;
                res_next.count     = CNT_W'(total_reg);
                state_next         = S_RESP;
            end
            S_RD_OFF: begin
                res_next.count = CNT_W'(off_rdata);
                state_next     = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // register write clears the block, as start does
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_NUM_COLUMNS: ncol_next = cfg_clamped_col;
                CFG_NUM_ROWS:    nrow_next = cfg_clamped_row;
                default:         ncol_next = ncol_reg;
            endcase
            total_next = '0;
            built_next = 1'b0;
            clr_next   = '0;
            state_next = S_CLR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            total_reg   <= '0;
            built_reg   <= 1'b0;
            ncol_reg    <= CFG_W'(NCOL_RST);
            nrow_reg    <= CFG_W'(NROW_RST);
            clr_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            built_reg   <= built_next;
            ncol_reg    <= ncol_next;
            nrow_reg    <= nrow_next;
            clr_reg     <= clr_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg    <= col_next;
        c_reg      <= c_next;
        i_reg      <= i_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    sct_entry_mem #(
        .DEPTH (MAX_NONZEROS),
        .AW    (EAW)
    ) u_entry_mem (
        .aclk      (aclk),
        .ctl       (e_ctl),
        .ld_waddr  (EAW'(total_reg)),
        .ld_wdata  (ld_wdata),
        .ld_raddr  (EAW'(i_reg)),
        .ld_rdata  (ld_rdata),
        .out_waddr (EAW'(cur_rdata)),
        .out_wdata (out_wdata),
        .out_raddr (EAW'(in_pos)),
        .out_rdata (out_rdata)
    );

    sct_col_mem #(
        .DEPTH (MAX_COLUMNS),
        .AW    (CAW),
        .W     (NZW)
    ) u_col_mem (
        .aclk      (aclk),
        .ctl       (c_ctl),
        .cnt_waddr (cnt_waddr),
        .cnt_wdata (cnt_wdata),
        .cnt_raddr (cnt_raddr),
        .cnt_rdata (cnt_rdata),
        .cur_waddr (cur_waddr),
        .cur_wdata (cur_wdata),
        .cur_raddr (CAW'(ld_rdata.column)),
        .cur_rdata (cur_rdata),
        .off_waddr (CAW'(c_reg)),
        .off_wdata (sum),
        .off_raddr (CAW'(in_pos - POS_W'(1))),
        .off_rdata (off_rdata)
    );

endmodule

/* bench/sparse_csr_transpose_top_tb.sv */
module sparse_csr_transpose_top_tb import sct_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NNZ_MAX   = 4096;
    localparam int COL_MAX   = 1024;
    localparam int ROW_MAX   = 1024;
    localparam int CYCLE_CAP = 2000000;

    typedef struct {
        status_t     status;
        logic [31:0] value;
        logic [9:0]  orow;
        logic [9:0]  oidx;
        logic [12:0] count;
    } xpose_res_t;

    typedef struct {
        logic [2:0]  req;
        logic [9:0]  row;
        logic [9:0]  col;
        logic [31:0] value;
        logic [12:0] pos;
        bit          typed;
        status_t     st;
        logic [12:0] cnt;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [71:0] s_tdata = '0;
    logic [REQ_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic cfg_we = 1'b0;
    cfg_idx_t cfg_index = CFG_NUM_COLUMNS;
    logic [CFG_W-1:0] cfg_data = '0;

    sparse_csr_transpose_top uut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow state of the transpose
    int unsigned sh_cols, sh_rows, sh_total;
    bit sh_built;
    logic [9:0]  ld_row [NNZ_MAX];
    logic [9:0]  ld_col [NNZ_MAX];
    logic [31:0] ld_val [NNZ_MAX];
    int unsigned col_cnt [COL_MAX];
    int unsigned col_off [COL_MAX+1];
    logic [31:0] tp_val [NNZ_MAX];
    logic [9:0]  tp_idx [NNZ_MAX];
    logic [9:0]  tp_row [NNZ_MAX];

    xpose_res_t pending[$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 1'b0;

    function automatic void clear_shadow();
        foreach (col_cnt[i]) col_cnt[i] = 0;
        sh_total = 0;
        sh_built = 1'b0;
    endfunction

    function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void build_transpose();
        int unsigned cursor [COL_MAX];
        int unsigned dst;
        col_off[0] = 0;
        for (int c = 0; c < sh_cols; c++) begin
            col_off[c+1] = col_off[c] + col_cnt[c];
            cursor[c] = 0;
        end
        for (int i = 0; i < sh_total; i++) begin
            if (ld_col[i] < sh_cols) begin
                dst = col_off[ld_col[i]] + cursor[ld_col[i]];
                if (dst < NNZ_MAX) begin
                    tp_val[dst] = ld_val[i];
                    tp_idx[dst] = ld_row[i];
                    tp_row[dst] = ld_col[i];
                    cursor[ld_col[i]]++;
                end
            end
        end
        sh_built = 1'b1;
    endfunction

    function automatic xpose_res_t transpose_step(logic [2:0] req, logic [9:0] row,
            logic [9:0] col, logic [31:0] value, logic [12:0] pos);
        xpose_res_t r;
        r.status = ST_OK; r.value = '0; r.orow = '0; r.oidx = '0; r.count = '0;
        case (req)
            REQ_LOAD: begin
                if (row >= sh_rows || col >= sh_cols) r.status = ST_RANGE;
                else if (sh_total >= NNZ_MAX) r.status = ST_FULL;
                else begin
                    ld_row[sh_total] = row;
                    ld_col[sh_total] = col;
                    ld_val[sh_total] = value;
                    col_cnt[col]++;
                    sh_total++;
                    sh_built = 1'b0;
                    r.count = 13'(sh_total);
                end
            end
            REQ_BUILD: begin
                build_transpose();
                r.count = 13'(sh_total);
            end
            REQ_RD_ENTRY: begin
                if (!sh_built) r.status = ST_NOT_BUILT;
                else if (pos >= sh_total) r.status = ST_RANGE;
                else begin
                    r.value = tp_val[pos];
                    r.orow = tp_row[pos];
                    r.oidx = tp_idx[pos];
                    r.count = 13'(sh_total);
                end
            end
            REQ_RD_OFF: begin
                if (!sh_built) r.status = ST_NOT_BUILT;
                else if (pos > sh_cols) r.status = ST_RANGE;
                else r.count = 13'(col_off[pos]);
            end
            REQ_START: clear_shadow();
            default: r.count = 13'(sh_total);
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    // one request transaction; returns once accepted
    task automatic send_req(logic [2:0] req, logic [9:0] row, logic [9:0] col,
            logic [31:0] value, logic [12:0] pos, bit typed = 0,
            status_t st = ST_OK, logic [12:0] cnt = '0);
        xpose_res_t r;
        while (!quiet && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {7'd0, pos, value, col, row};
        do @(posedge aclk); while (!s_tready);
        r = transpose_step(req, row, col, value, pos);
        if (typed) begin
            r.status = st; r.value = '0; r.orow = '0; r.oidx = '0; r.count = cnt;
        end
        pending = {pending, r};
        @(negedge aclk);
    endtask

    task automatic write_cfg(cfg_idx_t idx, logic [CFG_W-1:0] data);
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(negedge aclk);
        // some margin before the write
        repeat (20) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_NUM_COLUMNS) sh_cols = clamp_cfg(32'(data), COL_MAX);
        else sh_rows = clamp_cfg(32'(data), ROW_MAX);
        clear_shadow();
    endtask

    task automatic random_req();
        int unsigned pick;
        logic [9:0] row, col;
        logic [12:0] pos;
        pick = $urandom_range(99);
        row = 10'($urandom_range(sh_rows - 1));
        col = 10'($urandom_range(sh_cols - 1));
        pos = 13'($urandom());
        if (pick < 60) begin
            if ($urandom_range(9) == 0) begin
                row = 10'($urandom());
                col = 10'($urandom());
            end
            send_req(REQ_LOAD, row, col, $urandom(), pos);
        end else if (pick < 68) begin
            send_req(REQ_BUILD, row, col, $urandom(), pos);
        end else if (pick < 84) begin
            if ($urandom_range(5) != 0) pos = 13'($urandom_range(sh_total + 1));
            send_req(REQ_RD_ENTRY, row, col, $urandom(), pos);
        end else if (pick < 95) begin
            if ($urandom_range(5) != 0) pos = 13'($urandom_range(sh_cols + 1));
            send_req(REQ_RD_OFF, row, col, $urandom(), pos);
        end else if (pick < 97) begin
            send_req(REQ_START, row, col, $urandom(), pos);
        end else begin
            send_req(3'($urandom_range(7, 5)), row, col, $urandom(), pos);
        end
    endtask

    always @(negedge aclk) m_tready <= quiet || ($urandom_range(99) >= 35);

    always @(posedge aclk) begin
        xpose_res_t e;
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("sparse_csr_transpose_top verification failed");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], 0);
            end else begin
                e = pending.pop_front();
                if (m_tdata[1:0] != e.status)
                    report_mismatch("status", 32'(m_tdata[1:0]), 32'(e.status));
                if (m_tdata[33:2] != e.value)
                    report_mismatch("out_value", m_tdata[33:2], e.value);
                if (m_tdata[43:34] != e.orow)
                    report_mismatch("out_row", 32'(m_tdata[43:34]), 32'(e.orow));
                if (m_tdata[53:44] != e.oidx)
                    report_mismatch("out_index", 32'(m_tdata[53:44]), 32'(e.oidx));
                if (m_tdata[66:54] != e.count)
                    report_mismatch("count", 32'(m_tdata[66:54]), 32'(e.count));
            end
        end
    end

    stim_row_t directed [] = '{
        '{REQ_RD_ENTRY, 0, 0, 0, 0, 1, ST_NOT_BUILT, 0},
        '{REQ_RD_OFF, 0, 0, 0, 0, 1, ST_NOT_BUILT, 0},
        '{REQ_LOAD, 1023, 1023, 32'hFFFF_FFFF, 0, 1, ST_OK, 1},
        '{REQ_LOAD, 0, 0, 0, 13'h1FFF, 1, ST_OK, 2},
        '{REQ_LOAD, 1023, 0, 32'h5A5A_A5A5, 0, 0, ST_OK, 0},
        '{REQ_LOAD, 5, 1023, 32'h1234_5678, 0, 0, ST_OK, 0},
        '{REQ_BUILD, 0, 0, 0, 0, 1, ST_OK, 4},
        '{REQ_RD_ENTRY, 0, 0, 0, 0, 0, ST_OK, 0},
        '{REQ_RD_ENTRY, 0, 0, 0, 1, 0, ST_OK, 0},
        '{REQ_RD_ENTRY, 0, 0, 0, 2, 0, ST_OK, 0},
        '{REQ_RD_ENTRY, 0, 0, 0, 3, 0, ST_OK, 0},
        '{REQ_RD_ENTRY, 0, 0, 0, 4, 1, ST_RANGE, 0},
        '{REQ_RD_ENTRY, 0, 0, 0, 13'h1FFF, 1, ST_RANGE, 0},
        '{REQ_RD_OFF, 0, 0, 0, 0, 1, ST_OK, 0},
        '{REQ_RD_OFF, 0, 0, 0, 1024, 1, ST_OK, 4},
        '{REQ_RD_OFF, 0, 0, 0, 1025, 1, ST_RANGE, 0},
        '{REQ_LOAD, 2, 1, 32'h0BAD_F00D, 0, 1, ST_OK, 5},
        '{REQ_RD_ENTRY, 0, 0, 0, 0, 1, ST_NOT_BUILT, 0},
        '{REQ_BUILD, 0, 0, 0, 0, 1, ST_OK, 5},
        '{REQ_BUILD, 0, 0, 0, 0, 1, ST_OK, 5},
        '{REQ_RD_OFF, 0, 0, 0, 2, 0, ST_OK, 0},
        '{3'd5, 0, 0, 0, 0, 1, ST_OK, 5},
        '{3'd7, 0, 0, 0, 0, 1, ST_OK, 5},
        '{REQ_START, 0, 0, 0, 0, 1, ST_OK, 0},
        '{REQ_RD_ENTRY, 0, 0, 0, 0, 1, ST_NOT_BUILT, 0}
    };

    // {columns, rows} as written, clamped by the block
    logic [CFG_W-1:0] cfg_plan [6][2] = '{
        '{11'd0, 11'd2047}, '{11'd3, 11'd2}, '{11'd16, 11'd16},
        '{11'd2047, 11'd0}, '{11'd1024, 11'd1024}, '{11'd40, 11'd700}
    };

    initial begin
        sh_cols = COL_MAX;
        sh_rows = ROW_MAX;
        clear_shadow();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_req(directed[i].req, directed[i].row, directed[i].col, directed[i].value,
                     directed[i].pos, directed[i].typed, directed[i].st, directed[i].cnt);

        foreach (cfg_plan[p]) begin
            write_cfg(CFG_NUM_COLUMNS, cfg_plan[p][0]);
            write_cfg(CFG_NUM_ROWS, cfg_plan[p][1]);
            quiet = (p == 2);
            repeat (180) random_req();
            quiet = 1'b0;
        end

        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("sparse_csr_transpose_top verification clean");
        end else begin
            $display("sparse_csr_transpose_top verification failed");
        end
        $finish;
    end
endmodule
